// File: rtl/pes_pkg.sv
// pes_pkg: constants, types and codes for the periodic event scheduler
// no dependencies
`timescale 1ns / 1ps
package pes_pkg;
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int LW       = ADDR_W + 2;
  localparam int USER_W   = 31;
  localparam int PER_W    = 16;
  localparam int DUE_W    = 40;
  localparam int ENT_W    = DUE_W + USER_W + PER_W;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_FETCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // entry packed so that one unsigned compare gives the service order
  typedef struct packed {
    logic [DUE_W-1:0]  due;
    logic [USER_W-1:0] user;
    logic [PER_W-1:0]  period;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_UP, S_UP_CMP, S_DN_ROOT, S_DN_L, S_DN_R, S_DN_CMP
  } state_t;
endpackage

// File: rtl/pes_ram.sv
// pes_ram: generic simple dual-port ram, registered read
// no dependencies
`timescale 1ns / 1ps
module pes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/periodic_event_scheduler.sv
// periodic_event_scheduler: min-heap of periodic users in one ram, hole-based sifts
// depends on pes_pkg and pes_ram
//
// An item is taken when start is high and busy is low; its one result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. Clear, rejected and unused-code items are not busy at all
// and give their result in the cycle after they are taken. An add is busy in
// an S_UP and S_UP_CMP pair per parent compared, plus a final S_UP when it
// rises to the root; a fetch is busy in S_DN_ROOT to read the root, in an
// S_DN_L, S_DN_R and S_DN_CMP step per pair of children compared and in one
// more S_DN_L when the entry sinks to a leaf. The result follows the last busy
// cycle. These steps are set by the single read port of the heap ram, one read
// per cycle.
`timescale 1ns / 1ps
module periodic_event_scheduler
  import pes_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        func,
  input  logic [USER_W-1:0] user_id,
  input  logic [PER_W-1:0]  period,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status,
  output logic [USER_W-1:0] due_user,
  output logic [DUE_W-1:0]  due_time,
  output logic [10:0]       entry_count
);
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] pidx, pidx_next;
  entry_t            x, x_next;
  entry_t            cl, cl_next;
  logic              has_r, has_r_next;
  logic              fin;
  logic [1:0]        status_next;
  logic [USER_W-1:0] due_user_next;
  logic [DUE_W-1:0]  due_time_next;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;
  logic [LW-1:0]     lidx, ridx;
  logic [DUE_W:0]    sum;

  pes_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lidx = {1'b0, idx, 1'b1};
  assign ridx = lidx + LW'(1);
  assign sum  = {1'b0, rdata.due} + (DUE_W + 1)'(rdata.period);
  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    count_next    = count;
    idx_next      = idx;
    pidx_next     = pidx;
    x_next        = x;
    cl_next       = cl;
    has_r_next    = has_r;
    fin           = 1'b0;
    status_next   = ST_OK;
    due_user_next = due_user;
    due_time_next = due_time;
    we            = 1'b0;
    waddr         = idx;
    wdata         = x;
    raddr         = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          due_user_next = '0;
          due_time_next = '0;
          case (func)
            FUNC_ADD: begin
              if (count >= CNT_W'(CAPACITY)) begin
                status_next = ST_FULL;
                fin         = 1'b1;
              end else begin
                x_next     = '{due: DUE_W'(period), user: user_id, period: period};
                idx_next   = count[ADDR_W-1:0];
                count_next = count + CNT_W'(1);
                state_next = S_UP;
              end
            end
            FUNC_FETCH: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
                fin         = 1'b1;
              end else begin
                raddr      = '0;
                state_next = S_DN_ROOT;
              end
            end
            FUNC_CLEAR: begin
              count_next = '0;
              fin        = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_UP: begin
        if (idx == '0) begin
          we         = 1'b1;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          pidx_next  = (idx - ADDR_W'(1)) >> 1;
          raddr      = (idx - ADDR_W'(1)) >> 1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (x < rdata) begin
          wdata      = rdata;
          idx_next   = pidx;
          state_next = S_UP;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DN_ROOT: begin
        due_user_next = rdata.user;
        due_time_next = rdata.due;
        x_next        = rdata;
        x_next.due    = sum[DUE_W] ? {DUE_W{1'b1}} : sum[DUE_W-1:0];
        idx_next      = '0;
        state_next    = S_DN_L;
      end
      S_DN_L: begin
        if (lidx >= LW'(count)) begin
          we         = 1'b1;
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr      = lidx[ADDR_W-1:0];
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        cl_next    = rdata;
        has_r_next = (ridx < LW'(count));
        raddr      = ridx[ADDR_W-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (has_r && (rdata < cl) && (rdata < x)) begin
          wdata      = rdata;
          idx_next   = ridx[ADDR_W-1:0];
          state_next = S_DN_L;
        end else if (cl < x && !(has_r && (rdata < cl))) begin
          wdata      = cl;
          idx_next   = lidx[ADDR_W-1:0];
          state_next = S_DN_L;
        end else begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= fin;
    end
    idx      <= idx_next;
    pidx     <= pidx_next;
    x        <= x_next;
    cl       <= cl_next;
    has_r    <= has_r_next;
    due_user <= due_user_next;
    due_time <= due_time_next;
    if (state == S_IDLE) begin
      status <= status_next;
    end
  end

  assign entry_count = 11'(count);

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY)) else $error("count above capacity");
  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy) else $error("ram write while idle");
  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("item dropped");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (due_user == '0 && due_time == '0))
    else $error("empty fetch with payload");
endmodule
